@@ rtl/core/rule_layer_first_fit_assigner_core_assert.svh @@
// Assertion macros for the rule layer first-fit assigner core.
// Used by the top level; no other dependencies.
`ifndef RULE_LAYER_FIRST_FIT_ASSIGNER_CORE_ASSERT_SVH
`define RULE_LAYER_FIRST_FIT_ASSIGNER_CORE_ASSERT_SVH
`ifndef SYNTH
`define RLA_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define RLA_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define RLA_ASSERT_IMPL(label, clk, rst_n, a, c)
`define RLA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/core/rla_pkg.sv @@
// Package for the rule layer first-fit assigner: types and range conversion.
// No dependencies.
`timescale 1ns / 1ps
package rla_pkg;
	localparam int AddrW = 32;
	localparam int LenW  = 6;

	typedef struct packed {
		logic [AddrW-1:0] slo;
		logic [AddrW-1:0] shi;
		logic [AddrW-1:0] dlo;
		logic [AddrW-1:0] dhi;
	} rule_rng_t;

	typedef struct packed {
		logic [5:0] layer;
		logic       opened_layer;
		logic [9:0] rule_slot;
		logic       store_full;
	} result_t;

	function automatic logic [63:0] to_range(input logic [31:0] a, input logic [5:0] l);
		logic [31:0] b;
		logic [31:0] span;
		b = a;
		span = 32'hFFFF_FFFF;
		if (l == 6'd0) begin
			b = 32'd0;
		end else begin
			span = 32'hFFFF_FFFF >> l;
			if (l <= 6'd8) begin
				b = {a[31:24] & ~(8'hFF >> l[3:0]), 24'd0};
			end else if (l <= 6'd16) begin
				b = {a[31:16], 16'd0};
			end else if (l <= 6'd24) begin
				b = {a[31:8], 8'd0};
			end
		end
		return {b, b + span};
	endfunction

	function automatic logic overlaps(input logic [31:0] tl, input logic [31:0] th,
			input logic [31:0] ml, input logic [31:0] mh);
		return (tl < ml && th > ml) || (tl > ml && tl < mh) || (tl == ml);
	endfunction
endpackage

@@ rtl/core/rla_if.sv @@
// Valid/ready channel interfaces for input and result words.
// Depends on rla_pkg.
`timescale 1ns / 1ps
interface rla_in_if import rla_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] src_address;
	logic [5:0]  src_length;
	logic [31:0] dst_address;
	logic [5:0]  dst_length;
	modport source(output valid, src_address, src_length, dst_address, dst_length,
		input ready);
	modport sink(input valid, src_address, src_length, dst_address, dst_length,
		output ready);
endinterface

interface rla_out_if import rla_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [5:0] layer;
	logic       opened_layer;
	logic [9:0] rule_slot;
	logic       store_full;
	modport source(output valid, layer, opened_layer, rule_slot, store_full, input ready);
	modport sink(input valid, layer, opened_layer, rule_slot, store_full, output ready);
endinterface

@@ rtl/core/rule_layer_first_fit_assigner_core.sv @@
// The scan reads one stored rule per cycle from the range memory port.
// The back end handles one rule at a time; a two-word queue decouples the front.
// Dropped rules are taken from the input and give no result.
// Reset is asynchronous: counters cleared, min_length set to 5, memories left as is.
`timescale 1ns / 1ps
`include "rule_layer_first_fit_assigner_core_assert.svh"
module rule_layer_first_fit_assigner_core import rla_pkg::*; #(
	parameter int MAX_RULES = 1024,
	parameter int MAX_LAYERS = 64
) (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [5:0] cfg_wdata,
	rla_in_if.sink    in_ch,
	rla_out_if.source out_ch
);
	logic [5:0] min_length_q;
	logic       q_valid, q_ready, busy;
	rule_rng_t  q_data;
	result_t    r_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= 6'd5;
		end else if (cfg_we) begin
			min_length_q <= cfg_wdata;
		end
	end

	rla_front u_front (.clk(clk), .arst_n(arst_n), .min_length(min_length_q), .in_ch(in_ch),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

	rla_back #(.MaxRules(MAX_RULES), .MaxLayers(MAX_LAYERS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.r_valid(out_ch.valid), .r_ready(out_ch.ready), .r_data(r_data), .busy(busy));

	assign out_ch.layer = r_data.layer;
	assign out_ch.opened_layer = r_data.opened_layer;
	assign out_ch.rule_slot = r_data.rule_slot;
	assign out_ch.store_full = r_data.store_full;

	`RLA_ASSERT_IMPL(a_out_busy, clk, arst_n, out_ch.valid, busy)
	`RLA_ASSERT_IMPL(a_take_idle, clk, arst_n, q_valid && q_ready, !busy)
	`RLA_ASSERT_NEXT(a_full_clean, clk, arst_n, out_ch.valid && out_ch.store_full,
		out_ch.valid || !busy)
endmodule

@@ rtl/core/rla_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rla_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/core/rla_front.sv @@
// Front end: accepts input words, filters short prefixes and converts ranges.
// Depends on rla_pkg and rla_if.
`timescale 1ns / 1ps
module rla_front import rla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [5:0] min_length,
	rla_in_if.sink    in_ch,
	output logic      q_valid,
	input  logic      q_ready,
	output rule_rng_t q_data
);
	localparam int QDepth = 2;
	rule_rng_t  fifo_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       keep, push, pop;
	logic [63:0] sr, dr;

	assign keep = (in_ch.src_length > min_length || in_ch.dst_length > min_length)
		&& in_ch.src_length <= 6'd32 && in_ch.dst_length <= 6'd32;
	assign in_ch.ready = (cnt_q != 2'(QDepth));
	assign push = in_ch.valid && in_ch.ready && keep;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = fifo_q[rp_q];
	assign sr = to_range(in_ch.src_address, in_ch.src_length);
	assign dr = to_range(in_ch.dst_address, in_ch.dst_length);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{slo: sr[63:32], shi: sr[31:0], dlo: dr[63:32], dhi: dr[31:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ rtl/core/rla_back.sv @@
// Back end: scans stored rules, picks the first fitting layer, stores the rule.
// Depends on rla_pkg and rla_ram.
`timescale 1ns / 1ps
module rla_back import rla_pkg::*; #(
	parameter int MaxRules = 1024,
	parameter int MaxLayers = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  rule_rng_t q_data,
	output logic      r_valid,
	input  logic      r_ready,
	output result_t   r_data,
	output logic      busy
);
	localparam int RW = $clog2(MaxRules);
	localparam int LW = $clog2(MaxLayers);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_PICK = 5'b00100,
		S_DONE = 5'b01000,
		S_OUT  = 5'b10000
	} st_t;

	st_t          st_q;
	rule_rng_t    cur_q;
	logic [RW:0]  rule_count_q;
	logic [LW:0]  layer_count_q;
	logic [RW:0]  rd_idx_q;
	logic         rd_vld_q;
	logic [LW:0]  pick_q;
	logic [MaxLayers-1:0] seen_q, exact_q, dseen_q;
	logic [127:0] rng_rd;
	logic [LW-1:0] lay_rd;
	logic         we;
	result_t      res_q;

	assign we = (st_q == S_DONE) && !res_q.store_full;

	rla_ram #(.Width(128), .Depth(MaxRules)) u_rng (
		.clk(clk), .we(we), .waddr(rule_count_q[RW-1:0]), .wdata(cur_q),
		.raddr(rd_idx_q[RW-1:0]), .rdata(rng_rd));
	rla_ram #(.Width(LW), .Depth(MaxRules)) u_lay (
		.clk(clk), .we(we), .waddr(rule_count_q[RW-1:0]), .wdata(pick_q[LW-1:0]),
		.raddr(rd_idx_q[RW-1:0]), .rdata(lay_rd));

	assign q_ready = (st_q == S_IDLE);
	assign r_valid = (st_q == S_OUT);
	assign r_data = res_q;
	assign busy = (st_q != S_IDLE);

	logic ok_j;
	assign ok_j = exact_q[pick_q[LW-1:0]] || !seen_q[pick_q[LW-1:0]]
		|| !dseen_q[pick_q[LW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rule_count_q <= '0;
			layer_count_q <= '0;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
			pick_q <= '0;
			seen_q <= '0;
			exact_q <= '0;
			dseen_q <= '0;
			res_q <= '0;
			cur_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_data;
						seen_q <= '0;
						exact_q <= '0;
						dseen_q <= '0;
						rd_idx_q <= '0;
						rd_vld_q <= 1'b0;
						pick_q <= '0;
						if (rule_count_q == (RW+1)'(MaxRules)) begin
							res_q <= '{layer: '0, opened_layer: 1'b0, rule_slot: '0,
								store_full: 1'b1};
							st_q <= S_OUT;
						end else begin
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_vld_q) begin
						if (!seen_q[lay_rd] && overlaps(cur_q.slo, cur_q.shi,
								rng_rd[127:96], rng_rd[95:64])) begin
							seen_q[lay_rd] <= 1'b1;
							exact_q[lay_rd] <= (rng_rd == cur_q);
						end
						if (overlaps(cur_q.dlo, cur_q.dhi, rng_rd[63:32], rng_rd[31:0])) begin
							dseen_q[lay_rd] <= 1'b1;
						end
					end
					if (rd_idx_q < rule_count_q) begin
						rd_vld_q <= 1'b1;
						rd_idx_q <= rd_idx_q + (RW+1)'(1);
					end else begin
						rd_vld_q <= 1'b0;
						if (!rd_vld_q) begin
							st_q <= S_PICK;
						end
					end
				end
				S_PICK: begin
					if (pick_q >= layer_count_q) begin
						if (layer_count_q == (LW+1)'(MaxLayers)) begin
							res_q <= '{layer: '0, opened_layer: 1'b0, rule_slot: '0,
								store_full: 1'b1};
						end else begin
							layer_count_q <= layer_count_q + (LW+1)'(1);
							res_q <= '{layer: 6'(pick_q), opened_layer: 1'b1,
								rule_slot: 10'(rule_count_q), store_full: 1'b0};
						end
						st_q <= S_DONE;
					end else if (ok_j) begin
						res_q <= '{layer: 6'(pick_q), opened_layer: 1'b0,
							rule_slot: 10'(rule_count_q), store_full: 1'b0};
						st_q <= S_DONE;
					end else begin
						pick_q <= pick_q + (LW+1)'(1);
					end
				end
				S_DONE: begin
					if (!res_q.store_full) begin
						rule_count_q <= rule_count_q + (RW+1)'(1);
					end
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (r_ready) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
